[rtl/scc_pkg.sv]
package scc_pkg;

  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned CLASS_COUNT     = 48;
  localparam int unsigned MAX_CLASS_BYTES = 4096;
  localparam int unsigned BAND0_LIMIT     = 1024;
  localparam int unsigned BAND1_LIMIT     = 2048;
  localparam int unsigned SMALL_LIMIT     = 128;
  localparam int unsigned BAND0_ROUND     = 31;
  localparam int unsigned BAND1_ROUND     = 127;
  localparam int unsigned BAND2_ROUND     = 255;
  localparam int unsigned MAX_BATCH       = 64;
  localparam int unsigned COUNT_MAX       = 511;

  localparam logic [1:0] REG_SMALL_BATCH  = 2'd0;
  localparam logic [1:0] REG_MEDIUM_BATCH = 2'd1;
  localparam logic [1:0] REG_LARGE_BATCH  = 2'd2;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef logic [5:0] cls_idx_t;
  typedef logic [6:0] batch_t;
  typedef logic [8:0] count_t;

  typedef struct packed {
    batch_t small_batch;
    batch_t medium_batch;
    batch_t large_batch;
  } batch_cfg_t;

  typedef struct packed {
    logic     zero;
    logic     raw;
    cls_idx_t cls;
    batch_t   batch;
  } class_info_t;

  typedef struct packed {
    logic     en;
    cls_idx_t addr;
    count_t   data;
  } cnt_wr_t;

endpackage

[rtl/size_class_cache_refill_spill_unit.sv]
// size-class cache refill and spill bookkeeping
// a request is registered into the first stage, then the second stage, then the output registers that carry its result
// throughput: one request per cycle, busy stays low and the receiver cannot stall
// the class count memory read is registered, a same-class write in flight is bypassed
// synchronous active-low reset empties every class, clears the live count, restores batches
module size_class_cache_refill_spill_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_data_size,
  output logic        out_valid,
  output logic [5:0]  out_class_index,
  output logic        out_raw_path,
  output logic [6:0]  out_fetch_count,
  output logic [7:0]  out_return_count,
  output logic [8:0]  out_cached_after,
  output logic [31:0] out_live_after,
  output logic        out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  scc_pkg::batch_cfg_t  batch_cfg;
  scc_pkg::class_info_t s1_info;
  scc_pkg::cnt_wr_t     cnt_wr;
  scc_pkg::count_t      cnt_in;

  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic [31:0]          s1_data_r;
  logic                 s2_valid_r;
  logic                 s2_func_r;
  scc_pkg::class_info_t s2_info_r;
  logic [31:0]          live_r;
  logic [31:0]          live_nxt;

  logic                 out_valid_r;
  logic [5:0]           out_class_index_r;
  logic                 out_raw_path_r;
  logic [6:0]           out_fetch_count_r;
  logic [7:0]           out_return_count_r;
  logic [8:0]           out_cached_after_r;
  logic [31:0]          out_live_after_r;
  logic                 out_status_r;

  logic                 accept;
  logic                 do_count;
  scc_pkg::count_t      batch9;
  scc_pkg::count_t      limit;
  scc_pkg::count_t      cnt_inc;
  scc_pkg::count_t      cnt_nxt;
  logic [6:0]           fetch_nxt;
  logic [7:0]           give_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  scc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .batch_cfg (batch_cfg)
  );

  scc_classify u_classify (
    .data_size (s1_data_r),
    .batch_cfg (batch_cfg),
    .info      (s1_info)
  );

  scc_count_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (s1_info.cls),
    .wr       (cnt_wr),
    .rd_count (cnt_in)
  );

  // count update for the request in the second stage
  always_comb begin
    batch9    = {2'b00, s2_info_r.batch};
    limit     = {s2_info_r.batch, 2'b00};
    cnt_inc   = (cnt_in != 9'(scc_pkg::COUNT_MAX)) ? cnt_in + 9'd1 : cnt_in;
    fetch_nxt = 7'd0;
    give_nxt  = 8'd0;
    if (s2_func_r == scc_pkg::FUNC_ALLOC) begin
      if (cnt_in == 9'd0) begin
        fetch_nxt = s2_info_r.batch;
        cnt_nxt   = batch9 - 9'd1;
      end else begin
        cnt_nxt   = cnt_in - 9'd1;
      end
    end else begin
      if (cnt_inc > limit) begin
        give_nxt = {s2_info_r.batch, 1'b0};
        cnt_nxt  = cnt_inc - {1'b0, s2_info_r.batch, 1'b0};
      end else begin
        cnt_nxt  = cnt_inc;
      end
    end
  end

  assign do_count    = s2_valid_r && !s2_info_r.zero && !s2_info_r.raw;
  assign cnt_wr.en   = do_count;
  assign cnt_wr.addr = s2_info_r.cls;
  assign cnt_wr.data = cnt_nxt;

  always_comb begin
    live_nxt = live_r;
    if (s2_valid_r && !s2_info_r.zero) begin
      if (s2_func_r == scc_pkg::FUNC_ALLOC) begin
        if (live_r != 32'hFFFF_FFFF) begin
          live_nxt = live_r + 32'd1;
        end
      end else begin
        if (live_r != 32'd0) begin
          live_nxt = live_r - 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      live_r      <= 32'd0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      live_r      <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_func;
      s1_data_r <= in_data_size;
    end
    s2_func_r <= s1_func_r;
    s2_info_r <= s1_info;
    out_live_after_r   <= live_nxt;
    out_status_r       <= s2_info_r.zero;
    out_raw_path_r     <= !s2_info_r.zero && s2_info_r.raw;
    out_class_index_r  <= do_count ? s2_info_r.cls : 6'd0;
    out_fetch_count_r  <= do_count ? fetch_nxt : 7'd0;
    out_return_count_r <= do_count ? give_nxt : 8'd0;
    out_cached_after_r <= do_count ? cnt_nxt : 9'd0;
  end

  assign out_valid        = out_valid_r;
  assign out_class_index  = out_class_index_r;
  assign out_raw_path     = out_raw_path_r;
  assign out_fetch_count  = out_fetch_count_r;
  assign out_return_count = out_return_count_r;
  assign out_cached_after = out_cached_after_r;
  assign out_live_after   = out_live_after_r;
  assign out_status       = out_status_r;

`ifndef SYNTH
  a_start_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 out_valid)
    else $error("request did not produce a result three cycles later");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_class_index == 6'd0 && !out_raw_path &&
      out_fetch_count == 7'd0 && out_return_count == 8'd0 && out_cached_after == 9'd0))
    else $error("error result carries nonzero fields");

  a_raw_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_raw_path) |-> (out_class_index == 6'd0 &&
      out_fetch_count == 7'd0 && out_return_count == 8'd0 && out_cached_after == 9'd0))
    else $error("raw path result touched the class counts");

  a_refill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fetch_count != 7'd0) |->
      (out_cached_after == {2'b00, out_fetch_count} - 9'd1 && out_return_count == 8'd0))
    else $error("refill left an inconsistent cached count");
`endif

endmodule

[rtl/scc_cfg_regs.sv]
module scc_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output scc_pkg::batch_cfg_t  batch_cfg
);

  scc_pkg::batch_t small_r;
  scc_pkg::batch_t medium_r;
  scc_pkg::batch_t large_r;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_r  <= 7'd64;
      medium_r <= 7'd32;
      large_r  <= 7'd4;
    end else if (wr_en) begin
      case (reg_idx)
        scc_pkg::REG_SMALL_BATCH:  small_r  <= pwdata[6:0];
        scc_pkg::REG_MEDIUM_BATCH: medium_r <= pwdata[6:0];
        scc_pkg::REG_LARGE_BATCH:  large_r  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scc_pkg::REG_SMALL_BATCH:  prdata = {25'd0, small_r};
      scc_pkg::REG_MEDIUM_BATCH: prdata = {25'd0, medium_r};
      scc_pkg::REG_LARGE_BATCH:  prdata = {25'd0, large_r};
      default:                   prdata = 32'd0;
    endcase
  end

  assign batch_cfg.small_batch  = small_r;
  assign batch_cfg.medium_batch = medium_r;
  assign batch_cfg.large_batch  = large_r;

endmodule

[rtl/scc_classify.sv]
module scc_classify (
  input  logic [31:0]          data_size,
  input  scc_pkg::batch_cfg_t  batch_cfg,
  output scc_pkg::class_info_t info
);

  logic [32:0]     total;
  logic [12:0]     t;
  logic [10:0]     a;
  logic [12:0]     b_full;
  logic [10:0]     b;
  logic [12:0]     c;
  logic [5:0]      na;
  logic [3:0]      nb;
  logic [5:0]      nc;
  logic [6:0]      n;
  logic [6:0]      m;
  scc_pkg::batch_t batch_raw;

  assign total = {1'b0, data_size} + 33'(scc_pkg::HEADER_BYTES);
  assign t     = total[12:0];

  always_comb begin
    a      = (t < 13'(scc_pkg::BAND0_LIMIT)) ? t[10:0] : 11'(scc_pkg::BAND0_LIMIT);
    b_full = (t > 13'(scc_pkg::BAND0_LIMIT)) ? t - 13'(scc_pkg::BAND0_LIMIT) : 13'd0;
    b      = (b_full > 13'(scc_pkg::BAND0_LIMIT)) ? 11'(scc_pkg::BAND0_LIMIT) : b_full[10:0];
    c      = (t > 13'(scc_pkg::BAND1_LIMIT)) ? t - 13'(scc_pkg::BAND1_LIMIT) : 13'd0;
    na     = 6'((12'(a) + 12'(scc_pkg::BAND0_ROUND)) >> 5);
    nb     = 4'((12'(b) + 12'(scc_pkg::BAND1_ROUND)) >> 7);
    nc     = 6'((14'(c) + 14'(scc_pkg::BAND2_ROUND)) >> 8);
    n      = 7'(na) + 7'(nb) + 7'(nc);
    m      = (n != 7'd0) ? n - 7'd1 : 7'd0;
  end

  always_comb begin
    if (t <= 13'(scc_pkg::SMALL_LIMIT)) begin
      batch_raw = batch_cfg.small_batch;
    end else if (t <= 13'(scc_pkg::BAND0_LIMIT)) begin
      batch_raw = batch_cfg.medium_batch;
    end else begin
      batch_raw = batch_cfg.large_batch;
    end
  end

  assign info.zero  = (data_size == 32'd0);
  assign info.raw   = (total > 33'(scc_pkg::MAX_CLASS_BYTES));
  assign info.cls   = (m > 7'(scc_pkg::CLASS_COUNT - 1)) ? 6'(scc_pkg::CLASS_COUNT - 1)
                                                         : m[5:0];
  assign info.batch = (batch_raw == 7'd0) ? 7'd1 :
                      (batch_raw > 7'(scc_pkg::MAX_BATCH)) ? 7'(scc_pkg::MAX_BATCH) :
                      batch_raw;

endmodule

[rtl/scc_count_mem.sv]
module scc_count_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  scc_pkg::cls_idx_t rd_addr,
  input  scc_pkg::cnt_wr_t  wr,
  output scc_pkg::count_t   rd_count
);

  scc_pkg::count_t                     mem_r [scc_pkg::CLASS_COUNT];
  logic [scc_pkg::CLASS_COUNT-1:0]     valid_r;
  scc_pkg::count_t                     rd_data_r;
  logic                                rd_vld_r;
  logic                                byp_r;
  scc_pkg::count_t                     byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_data_r  <= mem_r[rd_addr];
    byp_data_r <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
      byp_r    <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_count = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : 9'd0);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    scc_pkg::cls_idx_t cls;
    logic              raw;
    scc_pkg::batch_t   fetch;
    logic [7:0]        give;
    scc_pkg::count_t   cached;
    logic [31:0]       live;
    logic              status;
  } result_t;

  typedef struct packed {
    logic        func;
    logic [31:0] data;
    logic        typed;
    result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [31:0] in_data_size;
  logic        out_valid;
  logic [5:0]  out_class_index;
  logic        out_raw_path;
  logic [6:0]  out_fetch_count;
  logic [7:0]  out_return_count;
  logic [8:0]  out_cached_after;
  logic [31:0] out_live_after;
  logic        out_status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // typed expectation travels with the transaction it belongs to
  logic    row_typed;
  result_t row_want;

  scc_pkg::batch_t batch_small;
  scc_pkg::batch_t batch_medium;
  scc_pkg::batch_t batch_large;
  scc_pkg::count_t class_cnt [scc_pkg::CLASS_COUNT];
  logic [31:0]     live_cnt;

  result_t refill_expect_q[$];
  int      mismatches;
  int      idle_cycles;

  size_class_cache_refill_spill_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_data_size     (in_data_size),
    .out_valid        (out_valid),
    .out_class_index  (out_class_index),
    .out_raw_path     (out_raw_path),
    .out_fetch_count  (out_fetch_count),
    .out_return_count (out_return_count),
    .out_cached_after (out_cached_after),
    .out_live_after   (out_live_after),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t predict_refill(input logic rel, input logic [31:0] data);
    result_t     r;
    logic [32:0] total;
    int unsigned t, a, b, c, n, bat, cnt, limit;
    r = '0;
    r.live = live_cnt;
    if (data == 32'd0) begin
      r.status = 1'b1;
      return r;
    end
    total = {1'b0, data} + 33'(scc_pkg::HEADER_BYTES);
    if (total > 33'(scc_pkg::MAX_CLASS_BYTES)) begin
      r.raw = 1'b1;
    end else begin
      t = int'(total[12:0]);
      a = t < scc_pkg::BAND0_LIMIT ? t : scc_pkg::BAND0_LIMIT;
      b = t > scc_pkg::BAND0_LIMIT ? t - scc_pkg::BAND0_LIMIT : 0;
      if (b > scc_pkg::BAND0_LIMIT) b = scc_pkg::BAND0_LIMIT;
      c = t > scc_pkg::BAND1_LIMIT ? t - scc_pkg::BAND1_LIMIT : 0;
      n = ((a + scc_pkg::BAND0_ROUND) >> 5) + ((b + scc_pkg::BAND1_ROUND) >> 7) +
          ((c + scc_pkg::BAND2_ROUND) >> 8);
      n = n > 0 ? n - 1 : 0;
      if (n > scc_pkg::CLASS_COUNT - 1) n = scc_pkg::CLASS_COUNT - 1;
      if (t <= scc_pkg::SMALL_LIMIT) bat = batch_small;
      else if (t <= scc_pkg::BAND0_LIMIT) bat = batch_medium;
      else bat = batch_large;
      if (bat == 0) bat = 1;
      if (bat > scc_pkg::MAX_BATCH) bat = scc_pkg::MAX_BATCH;
      cnt = class_cnt[n];
      if (rel == scc_pkg::FUNC_ALLOC) begin
        if (cnt == 0) begin
          r.fetch = scc_pkg::batch_t'(bat);
          cnt = bat;
        end
        cnt = cnt - 1;
      end else begin
        limit = bat * 4;
        if (cnt < scc_pkg::COUNT_MAX) cnt = cnt + 1;
        if (cnt > limit) begin
          r.give = 8'(limit / 2);
          cnt = cnt - limit / 2;
        end
      end
      class_cnt[n] = scc_pkg::count_t'(cnt);
      r.cls = scc_pkg::cls_idx_t'(n);
      r.cached = scc_pkg::count_t'(cnt);
    end
    if (rel == scc_pkg::FUNC_ALLOC) begin
      if (live_cnt != 32'hFFFF_FFFF) live_cnt = live_cnt + 1;
    end else begin
      if (live_cnt != 32'd0) live_cnt = live_cnt - 1;
    end
    r.live = live_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (refill_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no transaction pending");
        end else begin
          want = refill_expect_q.pop_front();
          check_field("class_index", 32'(want.cls), 32'(out_class_index));
          check_field("raw_path", 32'(want.raw), 32'(out_raw_path));
          check_field("fetch_count", 32'(want.fetch), 32'(out_fetch_count));
          check_field("return_count", 32'(want.give), 32'(out_return_count));
          check_field("cached_after", 32'(want.cached), 32'(out_cached_after));
          check_field("live_after", want.live, out_live_after);
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if (start && !busy) begin
        pred = predict_refill(in_func, in_data_size);
        refill_expect_q = {refill_expect_q, (row_typed ? row_want : pred)};
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            scc_pkg::REG_SMALL_BATCH: batch_small = pwdata[6:0];
            scc_pkg::REG_MEDIUM_BATCH: batch_medium = pwdata[6:0];
            scc_pkg::REG_LARGE_BATCH: batch_large = pwdata[6:0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            scc_pkg::REG_SMALL_BATCH: check_field("small_batch", 32'(batch_small), prdata);
            scc_pkg::REG_MEDIUM_BATCH: check_field("medium_batch", 32'(batch_medium), prdata);
            scc_pkg::REG_LARGE_BATCH: check_field("large_batch", 32'(batch_large), prdata);
            default: ;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic f, input logic [31:0] d, input logic typed,
                           input result_t want, input bit no_gaps);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_data_size <= d;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (refill_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [1:0] idx, input scc_pkg::batch_t v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & 32'hFFFF_FF80) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  stim_row_t dir_rows [24] = '{
    '{scc_pkg::FUNC_ALLOC, 32'd0, 1'b1, '{6'd0, 1'b0, 7'd0, 8'd0, 9'd0, 32'd0, 1'b1}},
    '{scc_pkg::FUNC_RELEASE, 32'd0, 1'b1, '{6'd0, 1'b0, 7'd0, 8'd0, 9'd0, 32'd0, 1'b1}},
    '{scc_pkg::FUNC_RELEASE, 32'd100, 1'b1, '{6'd3, 1'b0, 7'd0, 8'd0, 9'd1, 32'd0, 1'b0}},
    '{scc_pkg::FUNC_ALLOC, 32'd1, 1'b1, '{6'd0, 1'b0, 7'd64, 8'd0, 9'd63, 32'd1, 1'b0}},
    '{scc_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b1, 7'd0, 8'd0, 9'd0, 32'd2, 1'b0}},
    '{scc_pkg::FUNC_ALLOC, 32'd4080, 1'b1, '{6'd47, 1'b0, 7'd4, 8'd0, 9'd3, 32'd3, 1'b0}},
    '{scc_pkg::FUNC_ALLOC, 32'd4081, 1'b1, '{6'd0, 1'b1, 7'd0, 8'd0, 9'd0, 32'd4, 1'b0}},
    '{scc_pkg::FUNC_RELEASE, 32'd4081, 1'b1, '{6'd0, 1'b1, 7'd0, 8'd0, 9'd0, 32'd3, 1'b0}},
    '{scc_pkg::FUNC_RELEASE, 32'hFFFF_FFEF, 1'b1, '{6'd0, 1'b1, 7'd0, 8'd0, 9'd0, 32'd2, 1'b0}},
    '{scc_pkg::FUNC_ALLOC, 32'd0, 1'b1, '{6'd0, 1'b0, 7'd0, 8'd0, 9'd0, 32'd2, 1'b1}},
    '{scc_pkg::FUNC_ALLOC,   32'd112,        1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd113,        1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd1008,       1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd1009,       1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd2032,       1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd2033,       1'b0, '0},
    '{scc_pkg::FUNC_RELEASE, 32'd1008,       1'b0, '0},
    '{scc_pkg::FUNC_RELEASE, 32'd16,         1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd17,         1'b0, '0},
    '{scc_pkg::FUNC_RELEASE, 32'h8000_0000,  1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'h7FFF_FFFF,  1'b0, '0},
    '{scc_pkg::FUNC_ALLOC,   32'd3000,       1'b0, '0},
    '{scc_pkg::FUNC_RELEASE, 32'd3000,       1'b0, '0},
    '{scc_pkg::FUNC_RELEASE, 32'd0,          1'b0, '0}
  };

  scc_pkg::batch_t ph_cfg [PHASES][3] = '{
    '{7'd64, 7'd32, 7'd4}, '{7'd1, 7'd1, 7'd1}, '{7'd0, 7'd0, 7'd0},
    '{7'd127, 7'd127, 7'd127}, '{7'd64, 7'd64, 7'd64}, '{7'd2, 7'd3, 7'd1},
    '{7'd0, 7'd0, 7'd0}, '{7'd0, 7'd0, 7'd0}
  };
  int rel_pct [PHASES] = '{50, 50, 70, 40, 65, 55, 50, 60};

  initial begin
    int          ph;
    int          i;
    int          k;
    int          r;
    bit          no_gaps;
    logic        f;
    logic [31:0] d;
    logic [12:0] hot [4];
    rst_n = 1'b0;
    start = 1'b0;
    in_func = scc_pkg::FUNC_ALLOC;
    in_data_size = 32'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    row_typed = 1'b0;
    row_want = '0;
    mismatches = 0;
    idle_cycles = 0;
    batch_small = 7'd64;
    batch_medium = 7'd32;
    batch_large = 7'd4;
    live_cnt = 32'd0;
    for (i = 0; i < scc_pkg::CLASS_COUNT; i++) class_cnt[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 24; i++)
      send_item(dir_rows[i].func, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want, 1'b0);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        if (ph == 6)
          for (k = 0; k < 3; k++) ph_cfg[ph][k] = scc_pkg::batch_t'($urandom_range(0, 127));
        if (ph == 7)
          for (k = 0; k < 3; k++) ph_cfg[ph][k] = scc_pkg::batch_t'($urandom_range(1, 64));
        apb_access(1'b1, scc_pkg::REG_SMALL_BATCH, ph_cfg[ph][0]);
        apb_access(1'b1, scc_pkg::REG_MEDIUM_BATCH, ph_cfg[ph][1]);
        apb_access(1'b1, scc_pkg::REG_LARGE_BATCH, ph_cfg[ph][2]);
        if (ph == 5)
          apb_access(1'b1, REG_UNUSED, scc_pkg::batch_t'($urandom_range(0, 127)));
        apb_access(1'b0, scc_pkg::REG_SMALL_BATCH, '0);
        apb_access(1'b0, scc_pkg::REG_MEDIUM_BATCH, '0);
        apb_access(1'b0, scc_pkg::REG_LARGE_BATCH, '0);
      end
      hot[0] = 13'($urandom_range(17, 128));
      hot[1] = 13'($urandom_range(129, 1024));
      hot[2] = 13'($urandom_range(1025, 4096));
      hot[3] = 13'($urandom_range(17, 4096));
      no_gaps = (ph % 3 == 1);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) d = 32'(hot[$urandom_range(0, 3)]) - scc_pkg::HEADER_BYTES;
        else if (r < 82) d = $urandom_range(1, 4080);
        else if (r < 87) d = 32'd0;
        else if (r < 94) d = $urandom_range(4081, 32'hFFFF_FFFF);
        else d = $urandom;
        f = ($urandom_range(0, 99) < rel_pct[ph]) ? scc_pkg::FUNC_RELEASE : scc_pkg::FUNC_ALLOC;
        send_item(f, d, 1'b0, '0, no_gaps);
      end
    end

    settle();
    if (mismatches == 0 && refill_expect_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/scc_pkg.sv
rtl/scc_cfg_regs.sv
rtl/scc_classify.sv
rtl/scc_count_mem.sv
rtl/size_class_cache_refill_spill_unit.sv
tb/sv/tb.sv
